// ===== hdl/arm_banked_register_file_top_macros.svh =====
// assertion macros for the banked register file
// used by arm_banked_register_file_top; expects clk and arst_n in scope
`ifndef ARM_BANKED_REGISTER_FILE_TOP_MACROS_SVH
`define ARM_BANKED_REGISTER_FILE_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define ABRF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define ABRF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/arbrf_pkg.sv =====
// shared types, codes and decode functions for the banked register file
// no dependencies
package arbrf_pkg;

	localparam int NUM_PHYS = 37;
	localparam int PHYS_W   = $clog2(NUM_PHYS);
	localparam int DATA_W   = 32;

	// logical register indexes
	localparam logic [4:0] LREG_R8   = 5'd8;
	localparam logic [4:0] LREG_R13  = 5'd13;
	localparam logic [4:0] LREG_R14  = 5'd14;
	localparam logic [4:0] LREG_CPSR = 5'd16;
	localparam logic [4:0] LREG_SPSR = 5'd17;

	// physical layout anchors
	localparam logic [PHYS_W-1:0] PHYS_CPSR     = PHYS_W'(16);
	localparam logic [PHYS_W-1:0] PHYS_FIQ_BASE = PHYS_W'(17);
	localparam logic [PHYS_W-1:0] PHYS_SPSR_OFS = PHYS_W'(30);

	// mode bank codes
	localparam logic [2:0] BANK_USR     = 3'd0;
	localparam logic [2:0] BANK_SYS     = 3'd1;
	localparam logic [2:0] BANK_SVC     = 3'd2;
	localparam logic [2:0] BANK_ABT     = 3'd3;
	localparam logic [2:0] BANK_UND     = 3'd4;
	localparam logic [2:0] BANK_IRQ     = 3'd5;
	localparam logic [2:0] BANK_FIQ     = 3'd6;
	localparam logic [2:0] MODE_INVALID = 3'd7;

	// cpsr mode field codes
	localparam logic [4:0] MCODE_USR = 5'b10000;
	localparam logic [4:0] MCODE_FIQ = 5'b10001;
	localparam logic [4:0] MCODE_IRQ = 5'b10010;
	localparam logic [4:0] MCODE_SVC = 5'b10011;
	localparam logic [4:0] MCODE_ABT = 5'b10111;
	localparam logic [4:0] MCODE_UND = 5'b11011;
	localparam logic [4:0] MCODE_SYS = 5'b11111;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// decoded access, handed from the mapper to the storage
	typedef struct packed {
		logic              ok;
		logic              err;
		logic              wr;
		logic [PHYS_W-1:0] idx;
	} access_t;

	function automatic logic bank_has_spsr(input logic [2:0] bank);
		return (bank >= BANK_SVC) && (bank <= BANK_FIQ);
	endfunction

	// physical slot of a logical register as seen from a bank
	function automatic logic [PHYS_W-1:0] phys_index(input logic [4:0] lreg,
		input logic [2:0] bank);
		logic [PHYS_W-1:0] lr;
		logic [PHYS_W-1:0] bk;
		lr = PHYS_W'(lreg);
		bk = PHYS_W'(bank);
		if (lreg == LREG_SPSR)
			return PHYS_SPSR_OFS + bk;
		else if (bank >= BANK_SVC && bank <= BANK_IRQ && (lreg == LREG_R13 || lreg == LREG_R14))
			return (bk << 1) + lr;
		else if (bank == BANK_FIQ && lreg >= LREG_R8 && lreg <= LREG_R14)
			return lr + PHYS_FIQ_BASE;
		else
			return lr;
	endfunction

	function automatic logic [2:0] decode_mode(input logic [4:0] code);
		case (code)
			MCODE_USR: return BANK_USR;
			MCODE_SYS: return BANK_SYS;
			MCODE_SVC: return BANK_SVC;
			MCODE_ABT: return BANK_ABT;
			MCODE_UND: return BANK_UND;
			MCODE_IRQ: return BANK_IRQ;
			MCODE_FIQ: return BANK_FIQ;
			default:   return MODE_INVALID;
		endcase
	endfunction

endpackage

// ===== hdl/arbrf_map.sv =====
// request decode: legality check and logical-to-physical mapping
// depends on arbrf_pkg
module arbrf_map
	import arbrf_pkg::*;
(
	input  logic       op,
	input  logic [4:0] reg_index,
	input  logic [2:0] mode_bank,
	output access_t    acc
);

	logic in_range;
	logic spsr_bad;

	// range check and missing-spsr check against the requested bank
	always_comb begin
		in_range = (reg_index <= LREG_SPSR) && (mode_bank <= BANK_FIQ);
		spsr_bad = (reg_index == LREG_SPSR) && !bank_has_spsr(mode_bank);
		acc.err  = in_range && spsr_bad;
		acc.ok   = in_range && !spsr_bad;
		acc.wr   = (op == OP_WRITE);
		acc.idx  = phys_index(reg_index, mode_bank);
	end

endmodule

// ===== hdl/arbrf_regs.sv =====
// physical storage: 37-word memory with per-entry valid bits and a cpsr register
// depends on arbrf_pkg
module arbrf_regs
	import arbrf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  access_t           acc,
	input  logic [DATA_W-1:0] write_value,
	output logic [DATA_W-1:0] rdata,
	output logic              rhit,
	output logic [DATA_W-1:0] cpsr
);

	logic [DATA_W-1:0] mem [NUM_PHYS];
	logic [NUM_PHYS-1:0] valid_q;
	logic [DATA_W-1:0] rdata_q;
	logic              rhit_q;
	logic [DATA_W-1:0] cpsr_q;

	// memory write and registered read
	always_ff @(posedge clk) begin
		if (accept && acc.ok) begin
			if (acc.wr)
				mem[acc.idx] <= write_value;
			else
				rdata_q <= mem[acc.idx];
		end
	end

	// valid bits, read hit flag and cpsr, all cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rhit_q  <= 1'b0;
			cpsr_q  <= '0;
		end else if (accept && acc.ok) begin
			if (acc.wr) begin
				valid_q[acc.idx] <= 1'b1;
				if (acc.idx == PHYS_CPSR)
					cpsr_q <= write_value;
			end else begin
				rhit_q <= valid_q[acc.idx];
			end
		end
	end

	assign rdata = rdata_q;
	assign rhit  = rhit_q;
	assign cpsr  = cpsr_q;

endmodule

// ===== hdl/arm_banked_register_file_top.sv =====
// Banked register file, top level: 37 physical words, one access per item.
// Result: strobed on done in the cycle after start is taken.
// Throughput: one item per cycle; busy stays low, the single registered stage never stalls.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Reset (arst_n low, asynchronous): all registers read as zero, done low.
// depends on arbrf_pkg, arbrf_map, arbrf_regs, arm_banked_register_file_top_macros.svh
`include "arm_banked_register_file_top_macros.svh"

module arm_banked_register_file_top
	import arbrf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        op,
	input  logic [4:0]  reg_index,
	input  logic [2:0]  mode_bank,
	input  logic [31:0] write_value,
	output logic        done,
	output logic [31:0] read_data,
	output logic        error_code,
	output logic [2:0]  current_mode,
	output logic        current_has_spsr,
	output logic        privileged
);

	access_t           acc;
	logic              accept;
	logic [DATA_W-1:0] mem_rdata;
	logic              mem_rhit;
	logic [DATA_W-1:0] cpsr;

	logic done_s1;
	logic rd_s1;
	logic err_s1;
	logic cpsr_sel_s1;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	arbrf_map u_map (
		.op        (op),
		.reg_index (reg_index),
		.mode_bank (mode_bank),
		.acc       (acc)
	);

	arbrf_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.acc         (acc),
		.write_value (write_value),
		.rdata       (mem_rdata),
		.rhit        (mem_rhit),
		.cpsr        (cpsr)
	);

	// result stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1     <= 1'b0;
			rd_s1       <= 1'b0;
			err_s1      <= 1'b0;
			cpsr_sel_s1 <= 1'b0;
		end else begin
			done_s1     <= accept;
			rd_s1       <= accept && acc.ok && !acc.wr;
			err_s1      <= accept && acc.err;
			cpsr_sel_s1 <= acc.idx == PHYS_CPSR;
		end
	end

	// read data: cpsr from its own register, unwritten entries read as zero
	always_comb begin
		read_data = '0;
		if (rd_s1) begin
			if (cpsr_sel_s1)
				read_data = cpsr;
			else if (mem_rhit)
				read_data = mem_rdata;
		end
	end

	// status from cpsr as it stands after this transfer
	assign current_mode     = decode_mode(cpsr[4:0]);
	assign current_has_spsr = bank_has_spsr(current_mode);
	assign privileged       = (current_mode != MODE_INVALID) && (current_mode != BANK_USR);
	assign error_code       = err_s1;
	assign done             = done_s1;

	// checks
	`ABRF_ASSERT_NEXT(a_done_follows, start && !busy, done, "transfer taken but no result strobed")
	`ABRF_ASSERT_NOW(a_err_no_data, done && error_code, read_data == 32'd0, "error result carries data")
	`ABRF_ASSERT_NOW(a_spsr_priv, current_has_spsr, privileged, "mode with spsr not privileged")
	`ABRF_ASSERT_NOW(a_err_only_done, !done, !error_code, "error raised without a result")

endmodule
